[rtl/core/first_fit_heap_allocator_core_assert.svh]
// Assertion macros shared by the allocator core.
// Depends on nothing; files that assert include it.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FFHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ffha_pkg.sv]
// Package of the first-fit heap allocator: constants, codes and shared types.
// Used by the controller, the datapath and the top level.
package ffha_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int ADDR_W     = 16;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int HDR_W      = 7;
   localparam int BRK_W      = ADDR_W + 1;
   localparam int SUM_W      = ADDR_W + 2;
   localparam int STAT_W     = 3;
   localparam int ACT_W      = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RESIZE  = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_HEAP    = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_TABLE   = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_INVALID = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_ZERO    = 3'd4;

   localparam logic CSR_HEADER = 1'b0;
   localparam logic CSR_LIMIT  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_FIND_RD, S_FIND_CHK, S_FIT_RD, S_FIT_CHK,
      S_APPEND, S_MARK, S_PASS_RD, S_PASS_TAKE, S_DONE
   } ffha_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic              is_free;
   } ffha_entry_type;

   typedef struct packed {
      logic              capture;
      logic              set_status;
      logic [STAT_W-1:0] status_code;
      logic              scan_init;
      logic              mem_read;
      logic              idx_inc;
      logic              latch_live;
      logic              claim_fit;
      logic              append;
      logic              result_addr;
      logic              set_copy;
      logic              mark_free;
      logic              pass_init;
      logic              pass_take;
      logic              pass_flush;
      logic              load_output;
   } ffha_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             size_zero;
      logic             addr_zero;
      logic             idx_end;
      logic             fit_hit;
      logic             live_hit;
      logic             live_fits;
      logic             heap_fail;
      logic             table_full;
      logic             output_free;
      logic [CNT_W-1:0] count;
   } ffha_stat_type;

endpackage

[rtl/core/first_fit_heap_allocator_core.sv]
// Top level of the first-fit heap allocator: register port, controller and datapath.
// Depends on ffha_pkg, ffha_ctrl, ffha_datapath and the assertion macro header.
//
//   Port group   Direction  Handshake         Carries
//   req_*        in         valid / ready     action, req_size, req_address
//   rsp_*        out        valid / ready     result_address, copy_bytes, status
//   p*           in / out   psel, penable     header_bytes (0x0), heap_limit (0x4)
//
// One item is in work at a time; each passes at least through accept, decode and result load.
// A table walk visits each entry in an address state, then a registered memory read;
// this holds for the live-block search, for first fit and append and for the merge pass,
// each walking the current block count; the registered table read sets this.
// Reset is synchronous and empties the table at once through the block count.
// A finished result waits in the output register; the next item is accepted once
// that result has been moved into it, whether or not the consumer has taken it.
module first_fit_heap_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ffha_pkg::ACT_W-1:0]        req_action,
   input  logic [ffha_pkg::ADDR_W-1:0]       req_size,
   input  logic [ffha_pkg::ADDR_W-1:0]       req_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ffha_pkg::ADDR_W-1:0]       rsp_result_address,
   output logic [ffha_pkg::ADDR_W-1:0]       rsp_copy_bytes,
   output logic [ffha_pkg::STAT_W-1:0]       rsp_status,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ffha_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ffha_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ffha_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import ffha_pkg::*;

`include "first_fit_heap_allocator_core_assert.svh"

   ffha_cmd_type  cmd;
   ffha_stat_type stat;

   logic [HDR_W-1:0]  header_ff;
   logic [ADDR_W-1:0] limit_ff;

   // The register port never stalls; the register index is the word address bit.
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HDR_W'(16);
         limit_ff  <= {ADDR_W{1'b1}};
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[2])
            CSR_HEADER: header_ff <= pwdata[HDR_W-1:0];
            CSR_LIMIT:  limit_ff  <= pwdata[ADDR_W-1:0];
            default:    header_ff <= header_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_HEADER: prdata = CSR_DATA_W'(header_ff);
         CSR_LIMIT:  prdata = CSR_DATA_W'(limit_ff);
         default:    prdata = '0;
      endcase
   end

   // The controller decides each step; the datapath owns the table and all values.
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffha_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .header_bytes       (header_ff),
      .heap_limit         (limit_ff),
      .req_action         (req_action),
      .req_size           (req_size),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_address (rsp_result_address),
      .rsp_copy_bytes     (rsp_copy_bytes),
      .rsp_status         (rsp_status)
   );

   // Only one item is in work: a transfer in closes the input until the result is out.
   `FFHA_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "input accepted while an item was in work")

   // The block table can never hold more entries than it has rows.
   `FFHA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, stat.count <= CNT_W'(MAX_BLOCKS), "block count beyond table depth")

   // A result is only loaded when the output register is free to take it.
   `FFHA_ASSERT_NOW(a_load_free, clock, reset, cmd.load_output, !rsp_valid || rsp_ready, "result overwrote one not yet transferred")

endmodule

[rtl/core/ffha_ctrl.sv]
// Controller of the allocator: sequences search, append, release and merge.
// Depends on ffha_pkg.
module ffha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ffha_pkg::ffha_stat_type stat,
   output ffha_pkg::ffha_cmd_type  cmd
);
   import ffha_pkg::*;

   ffha_state_type state_ff, state_in;
   logic           move_ff, move_in;
   logic           resize_ff, resize_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         move_ff   <= 1'b0;
         resize_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         move_ff   <= move_in;
         resize_ff <= resize_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      move_in   = move_ff;
      resize_in = resize_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.scan_init = 1'b1;
            move_in       = 1'b0;
            resize_in     = 1'b0;
            unique case (stat.action)
               ACT_ALLOC: begin
                  if (stat.size_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_ZERO;
                     state_in        = S_DONE;
                  end else begin
                     state_in = S_FIT_RD;
                  end
               end
               ACT_RELEASE: begin
                  state_in = stat.addr_zero ? S_DONE : S_FIND_RD;
               end
               ACT_RESIZE: begin
                  if (stat.size_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_ZERO;
                     state_in        = stat.addr_zero ? S_DONE : S_FIND_RD;
                  end else if (stat.addr_zero) begin
                     state_in = S_FIT_RD;
                  end else begin
                     resize_in = 1'b1;
                     state_in  = S_FIND_RD;
                  end
               end
               default: begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STATUS_INVALID;
                  state_in        = S_DONE;
               end
            endcase
         end
         S_FIND_RD: begin
            if (stat.idx_end) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_INVALID;
               state_in        = S_DONE;
            end else begin
               cmd.mem_read = 1'b1;
               state_in     = S_FIND_CHK;
            end
         end
         S_FIND_CHK: begin
            if (stat.live_hit) begin
               cmd.latch_live = 1'b1;
               if (!resize_ff) begin
                  state_in = S_MARK;
               end else if (stat.live_fits) begin
                  cmd.result_addr = 1'b1;
                  state_in        = S_DONE;
               end else begin
                  cmd.scan_init = 1'b1;
                  move_in       = 1'b1;
                  state_in      = S_FIT_RD;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_FIND_RD;
            end
         end
         S_FIT_RD: begin
            if (stat.idx_end) begin
               state_in = S_APPEND;
            end else begin
               cmd.mem_read = 1'b1;
               state_in     = S_FIT_CHK;
            end
         end
         S_FIT_CHK: begin
            if (stat.fit_hit) begin
               cmd.claim_fit = 1'b1;
               cmd.set_copy  = move_ff;
               state_in      = move_ff ? S_MARK : S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_FIT_RD;
            end
         end
         S_APPEND: begin
            priority if (stat.heap_fail) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_HEAP;
               state_in        = S_DONE;
            end else if (stat.table_full) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_TABLE;
               state_in        = S_DONE;
            end else begin
               cmd.append   = 1'b1;
               cmd.set_copy = move_ff;
               state_in     = move_ff ? S_MARK : S_DONE;
            end
         end
         S_MARK: begin
            cmd.mark_free = 1'b1;
            cmd.pass_init = 1'b1;
            state_in      = S_PASS_RD;
         end
         S_PASS_RD: begin
            if (stat.idx_end) begin
               cmd.pass_flush = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.mem_read = 1'b1;
               cmd.idx_inc  = 1'b1;
               state_in     = S_PASS_TAKE;
            end
         end
         S_PASS_TAKE: begin
            cmd.pass_take = 1'b1;
            state_in      = S_PASS_RD;
         end
         S_DONE: begin
            if (stat.output_free) begin
               cmd.load_output = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/ffha_datapath.sv]
// Datapath of the allocator: block table memory, pointers, heap break and result.
// Depends on ffha_pkg; driven by ffha_ctrl.
module ffha_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ffha_pkg::ffha_cmd_type             cmd,
   output ffha_pkg::ffha_stat_type            stat,
   input  logic [ffha_pkg::HDR_W-1:0]         header_bytes,
   input  logic [ffha_pkg::ADDR_W-1:0]        heap_limit,
   input  logic [ffha_pkg::ACT_W-1:0]         req_action,
   input  logic [ffha_pkg::ADDR_W-1:0]        req_size,
   input  logic [ffha_pkg::ADDR_W-1:0]        req_address,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ffha_pkg::ADDR_W-1:0]        rsp_result_address,
   output logic [ffha_pkg::ADDR_W-1:0]        rsp_copy_bytes,
   output logic [ffha_pkg::STAT_W-1:0]        rsp_status
);
   import ffha_pkg::*;

   ffha_entry_type table_mem [MAX_BLOCKS];
   ffha_entry_type rd_ff;

   logic [ACT_W-1:0]  action_ff;
   logic [ADDR_W-1:0] size_ff, addr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BRK_W-1:0]  break_ff, break_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  widx_ff, widx_in;
   logic [IDX_W-1:0]  live_idx_ff;
   logic [ADDR_W-1:0] live_start_ff, live_len_ff;
   ffha_entry_type    held_ff, held_in;
   logic              have_ff, have_in;
   logic [ADDR_W-1:0] res_ff, res_in, copy_ff, copy_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_copy_ff;
   logic [STAT_W-1:0] rsp_status_ff;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   ffha_entry_type    mem_wdata;
   logic [ADDR_W-1:0] rd_payload, brk_payload;
   logic [SUM_W-1:0]  need, heap_total, merge_sum;
   logic [ADDR_W-1:0] merge_len;
   logic              merge_now;

   assign rd_payload  = ADDR_W'(rd_ff.start + ADDR_W'(header_bytes));
   assign brk_payload = ADDR_W'(break_ff[ADDR_W-1:0] + ADDR_W'(header_bytes));
   assign need        = SUM_W'(header_bytes) + SUM_W'(size_ff);
   assign heap_total  = SUM_W'(break_ff) + need;
   assign merge_sum   = SUM_W'(held_ff.length) + SUM_W'(header_bytes) + SUM_W'(rd_ff.length);
   assign merge_len   = (merge_sum > SUM_W'({ADDR_W{1'b1}})) ? {ADDR_W{1'b1}}
                                                             : merge_sum[ADDR_W-1:0];
   assign merge_now   = have_ff && held_ff.is_free && rd_ff.is_free;

   always_comb begin
      stat.action      = action_ff;
      stat.size_zero   = (size_ff == '0);
      stat.addr_zero   = (addr_ff == '0);
      stat.idx_end     = (idx_ff >= count_ff);
      stat.fit_hit     = rd_ff.is_free && (rd_ff.length >= size_ff);
      stat.live_hit    = !rd_ff.is_free && (rd_payload == addr_ff);
      stat.live_fits   = (rd_ff.length >= size_ff);
      stat.heap_fail   = (heap_total > SUM_W'(heap_limit));
      stat.table_full  = (count_ff >= CNT_W'(MAX_BLOCKS));
      stat.output_free = !rsp_valid_ff || rsp_ready;
      stat.count       = count_ff;
   end

   // Table write port: one source per cycle, chosen by the controller command.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff[IDX_W-1:0];
      mem_wdata = rd_ff;
      priority if (cmd.claim_fit) begin
         mem_we            = 1'b1;
         mem_wdata.is_free = 1'b0;
      end else if (cmd.append) begin
         mem_we    = 1'b1;
         mem_waddr = count_ff[IDX_W-1:0];
         mem_wdata = '{start: break_ff[ADDR_W-1:0], length: size_ff, is_free: 1'b0};
      end else if (cmd.mark_free) begin
         mem_we    = 1'b1;
         mem_waddr = live_idx_ff;
         mem_wdata = '{start: live_start_ff, length: live_len_ff, is_free: 1'b1};
      end else if (cmd.pass_take) begin
         mem_we    = have_ff;
         mem_waddr = widx_ff[IDX_W-1:0];
         mem_wdata = held_ff;
         if (merge_now) begin
            mem_wdata.length = merge_len;
         end
      end else if (cmd.pass_flush) begin
         mem_we    = have_ff;
         mem_waddr = widx_ff[IDX_W-1:0];
         mem_wdata = held_ff;
      end else begin
         mem_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_read) begin
         rd_ff <= table_mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      count_in  = count_ff;
      break_in  = break_ff;
      idx_in    = idx_ff;
      widx_in   = widx_ff;
      held_in   = held_ff;
      have_in   = have_ff;
      res_in    = res_ff;
      copy_in   = copy_ff;
      status_in = status_ff;
      if (cmd.capture) begin
         res_in    = '0;
         copy_in   = '0;
         status_in = STATUS_OK;
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.scan_init || cmd.pass_init) begin
         idx_in = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.pass_init) begin
         widx_in = '0;
         have_in = 1'b0;
      end
      if (cmd.claim_fit) begin
         res_in = rd_payload;
      end
      if (cmd.append) begin
         res_in   = brk_payload;
         count_in = count_ff + CNT_W'(1);
         break_in = heap_total[BRK_W-1:0];
      end
      if (cmd.result_addr) begin
         res_in = addr_ff;
      end
      if (cmd.set_copy) begin
         copy_in = live_len_ff;
      end
      if (cmd.pass_take) begin
         if (!have_ff) begin
            held_in = rd_ff;
            have_in = 1'b1;
         end else if (merge_now) begin
            widx_in = widx_ff + CNT_W'(1);
            have_in = 1'b0;
         end else begin
            widx_in = widx_ff + CNT_W'(1);
            held_in = rd_ff;
         end
      end
      if (cmd.pass_flush) begin
         count_in = widx_ff + CNT_W'(have_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         break_ff     <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         break_ff <= break_in;
         have_ff  <= have_in;
         if (cmd.load_output) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      widx_ff   <= widx_in;
      held_ff   <= held_in;
      res_ff    <= res_in;
      copy_ff   <= copy_in;
      status_ff <= status_in;
      if (cmd.capture) begin
         action_ff <= req_action;
         size_ff   <= req_size;
         addr_ff   <= req_address;
      end
      if (cmd.latch_live) begin
         live_idx_ff   <= idx_ff[IDX_W-1:0];
         live_start_ff <= rd_ff.start;
         live_len_ff   <= rd_ff.length;
      end
      if (cmd.load_output) begin
         rsp_addr_ff   <= res_ff;
         rsp_copy_ff   <= copy_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_copy_bytes     = rsp_copy_ff;
   assign rsp_status         = rsp_status_ff;

endmodule
